### rtl/per_client_window_rate_limiter_defines.svh
// ----------------------------------------------------------------------------
// per_client_window_rate_limiter_defines
// assertion macros used by the rate limiter rtl
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_WINDOW_RATE_LIMITER_DEFINES_SVH
`define PER_CLIENT_WINDOW_RATE_LIMITER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCWRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define PCWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/pcwrl_pkg.sv
// ----------------------------------------------------------------------------
// pcwrl_pkg
// types and constants of the per-client window rate limiter
// ----------------------------------------------------------------------------
`default_nettype none

package pcwrl_pkg;

    localparam int unsigned NUM_CLIENTS    = 256;
    localparam int unsigned CLIENT_W       = 8;
    localparam int unsigned REQ_W          = 16;
    localparam int unsigned TOK_W          = 31;
    localparam int unsigned TOKIN_W        = 24;
    localparam int unsigned TIME_W         = 32;
    localparam int unsigned RETRY_W        = 6;
    localparam int unsigned S_DATA_W       = 72;
    localparam int unsigned M_DATA_W       = 56;
    localparam int unsigned APB_ADDR_W     = 3;
    localparam int unsigned APB_DATA_W     = 32;

    localparam logic [TIME_W-1:0]  WINDOW_SECONDS = TIME_W'(60);
    localparam logic [TIME_W-1:0]  RETRY_MIN      = TIME_W'(1);
    localparam logic [TIME_W-1:0]  RETRY_MAX      = TIME_W'(63);
    localparam logic [TIME_W-1:0]  TOK_MAX        = TIME_W'(32'h7FFF_FFFF);

    localparam logic [REQ_W-1:0]   REQ_LIMIT_RESET = REQ_W'(60);
    localparam logic [TOK_W-1:0]   TOK_LIMIT_RESET = TOK_W'(100000);

    // register index, taken from paddr[2]
    localparam logic REG_REQ_LIMIT = 1'b0;
    localparam logic REG_TOK_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_RECORD = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // one client entry as held in the table memory
    typedef struct packed {
        logic              win_open;
        logic [REQ_W-1:0]  req_cnt;
        logic [TOK_W-1:0]  tok_tot;
        logic [TIME_W-1:0] win_start;
        logic [REQ_W-1:0]  req_lim;
        logic [TOK_W-1:0]  tok_lim;
    } entry_t;

endpackage

`default_nettype wire

### rtl/pcwrl_ram.sv
// ----------------------------------------------------------------------------
// pcwrl_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pcwrl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/per_client_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_client_window_rate_limiter
// fixed-window request and token limiter over a table of 256 client entries
// ----------------------------------------------------------------------------
// Input words on s_* carry an op (check, record tokens, clear entry), a client
// index, a token count and the current time in seconds. Each check returns one
// word on m_*: allowed, remaining requests, remaining tokens and a retry time.
// Record and clear words return nothing.
// The default limits sit in two APB registers (0x0 requests, 0x4 tokens) and
// are copied into an entry when it is created; write them only while idle.
// A word is accepted every cycle unless the output stalls. Its entry is read
// from the table memory in the accept cycle, updated in the update stage and
// written back; a write to the same client in the accept cycle is forwarded,
// so back-to-back words to one client need no bubble. A check result is
// registered in the output register when its word leaves the update stage.
// The result sits in an output register; while the receiver stalls, one more
// word is held in the update stage and then s_tready drops.
// Reset frees all entries at once (valid bits in flops) and restores the
// default limits to 60 requests and 100000 tokens; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_client_window_rate_limiter_defines.svh"

module per_client_window_rate_limiter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input words
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // op[1:0], client[9:2], token_count[33:10], now_sec[65:34], zero fill
    input  wire logic [pcwrl_pkg::S_DATA_W-1:0]      s_tdata,
    // result words
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // allowed[0], remaining_requests[16:1], remaining_tokens[48:17],
    // retry_after[54:49], zero fill
    output logic      [pcwrl_pkg::M_DATA_W-1:0]      m_tdata,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pcwrl_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [pcwrl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [pcwrl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready
);

    localparam int unsigned CW = pcwrl_pkg::CLIENT_W;
    localparam int unsigned RW = pcwrl_pkg::REQ_W;
    localparam int unsigned TW = pcwrl_pkg::TOK_W;
    localparam int unsigned IW = pcwrl_pkg::TOKIN_W;
    localparam int unsigned NW = pcwrl_pkg::TIME_W;

    // configuration registers
    logic [RW-1:0] cfg_req_reg;
    logic [TW-1:0] cfg_tok_reg;
    logic          cfg_wr;

    // entry valid flags
    logic [pcwrl_pkg::NUM_CLIENTS-1:0] entry_valid_reg;

    // update stage
    logic                  s1_valid_reg;
    pcwrl_pkg::op_t        s1_op_reg;
    logic [CW-1:0]         s1_client_reg;
    logic [IW-1:0]         s1_tok_reg;
    logic [NW-1:0]         s1_now_reg;
    logic                  fwd_hit_reg;
    pcwrl_pkg::entry_t     fwd_data_reg;

    // output register
    logic                  m_valid_reg;
    logic [pcwrl_pkg::M_DATA_W-1:0] m_data_reg;

    logic                  s_fire;
    logic                  s1_fire;
    logic [CW-1:0]         s_client;

    // table memory
    logic                  ram_wr_en;
    pcwrl_pkg::entry_t     ram_wr_data;
    pcwrl_pkg::entry_t     ram_rd_data;

    // entry datapath
    pcwrl_pkg::entry_t     stored;
    pcwrl_pkg::entry_t     cur;
    pcwrl_pkg::entry_t     win;
    pcwrl_pkg::entry_t     chk_entry;
    pcwrl_pkg::entry_t     rec_entry;
    logic                  opened;
    logic [NW-1:0]         elapsed;
    logic                  expire;
    logic [NW-1:0]         el_win;
    logic [NW-1:0]         tok_sum;
    logic [NW-1:0]         rec_sum;
    logic                  deny;
    logic [NW-1:0]         retry_wide;
    logic [pcwrl_pkg::RETRY_W-1:0] retry;
    logic [RW-1:0]         rem_req;
    logic [NW-1:0]         rem_tok;
    logic                  has_result;
    logic [pcwrl_pkg::M_DATA_W-1:0] result_data;

    // assertion helpers
    logic                  chk_fire;
    logic                  m_allowed;
    logic [pcwrl_pkg::RETRY_W-1:0] m_retry;

    // handshakes
    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;
    assign s_client = s_tdata[2 +: CW];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_req_reg <= pcwrl_pkg::REQ_LIMIT_RESET;
            cfg_tok_reg <= pcwrl_pkg::TOK_LIMIT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == pcwrl_pkg::REG_REQ_LIMIT) begin
                cfg_req_reg <= pwdata[RW-1:0];
            end else begin
                cfg_tok_reg <= pwdata[TW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == pcwrl_pkg::REG_TOK_LIMIT) begin
            prdata = {{(pcwrl_pkg::APB_DATA_W-TW){1'b0}}, cfg_tok_reg};
        end else begin
            prdata = {{(pcwrl_pkg::APB_DATA_W-RW){1'b0}}, cfg_req_reg};
        end
    end

    pcwrl_ram #(
        .WIDTH ($bits(pcwrl_pkg::entry_t)),
        .DEPTH (pcwrl_pkg::NUM_CLIENTS)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_client_reg),
        .wr_data (ram_wr_data),
        .rd_en   (s_fire),
        .rd_addr (s_client),
        .rd_data (ram_rd_data)
    );

    // update stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // update stage payload, with forwarding of the write in the accept cycle
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_op_reg     <= pcwrl_pkg::op_t'(s_tdata[1:0]);
            s1_client_reg <= s_client;
            s1_tok_reg    <= s_tdata[2+CW +: IW];
            s1_now_reg    <= s_tdata[2+CW+IW +: NW];
            fwd_hit_reg   <= ram_wr_en && (s1_client_reg == s_client);
            fwd_data_reg  <= ram_wr_data;
        end
    end

    // current entry, fresh when not yet created
    always_comb begin
        stored = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
        if (entry_valid_reg[s1_client_reg]) begin
            cur    = stored;
            opened = stored.win_open;
        end else begin
            cur         = '0;
            cur.req_lim = cfg_req_reg;
            cur.tok_lim = cfg_tok_reg;
            opened      = 1'b0;
        end
    end

    // window handling and admission decision
    always_comb begin
        elapsed = (s1_now_reg >= cur.win_start) ? (s1_now_reg - cur.win_start) : '0;
        expire  = !opened || (elapsed >= pcwrl_pkg::WINDOW_SECONDS);
        win     = cur;
        if (expire) begin
            win.req_cnt   = '0;
            win.tok_tot   = '0;
            win.win_start = s1_now_reg;
        end
        el_win  = expire ? '0 : elapsed;
        tok_sum = {1'b0, win.tok_tot} + {{(NW-IW){1'b0}}, s1_tok_reg};
        deny    = (win.req_cnt >= win.req_lim)
               || ((s1_tok_reg != '0) && (tok_sum > {1'b0, win.tok_lim}));

        retry_wide = (el_win < pcwrl_pkg::WINDOW_SECONDS)
                   ? (pcwrl_pkg::WINDOW_SECONDS - el_win) : '0;
        if (retry_wide < pcwrl_pkg::RETRY_MIN) begin
            retry_wide = pcwrl_pkg::RETRY_MIN;
        end
        if (retry_wide > pcwrl_pkg::RETRY_MAX) begin
            retry_wide = pcwrl_pkg::RETRY_MAX;
        end
        retry = deny ? retry_wide[pcwrl_pkg::RETRY_W-1:0] : '0;

        rem_req = (win.req_lim >= win.req_cnt) ? (win.req_lim - win.req_cnt) : '0;
        rem_tok = {1'b0, win.tok_lim} - {1'b0, win.tok_tot};

        // a check always leaves the window open
        chk_entry          = win;
        chk_entry.win_open = 1'b1;
        if (!deny) begin
            chk_entry.req_cnt = win.req_cnt + RW'(1);
        end

        result_data = {{(pcwrl_pkg::M_DATA_W-1-RW-NW-pcwrl_pkg::RETRY_W){1'b0}},
                       retry, rem_tok, rem_req, !deny};
    end

    // saturating token record
    always_comb begin
        rec_sum   = {1'b0, cur.tok_tot} + {{(NW-IW){1'b0}}, s1_tok_reg};
        rec_entry = cur;
        if (rec_sum > pcwrl_pkg::TOK_MAX) begin
            rec_entry.tok_tot = pcwrl_pkg::TOK_MAX[TW-1:0];
        end else begin
            rec_entry.tok_tot = rec_sum[TW-1:0];
        end
    end

    // write-back select per op
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_data = chk_entry;
        has_result  = 1'b0;
        case (s1_op_reg)
            pcwrl_pkg::OP_CHECK: begin
                ram_wr_en   = s1_fire;
                ram_wr_data = chk_entry;
                has_result  = 1'b1;
            end
            pcwrl_pkg::OP_RECORD: begin
                ram_wr_en   = s1_fire;
                ram_wr_data = rec_entry;
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // entry flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (s1_fire) begin
            case (s1_op_reg)
                pcwrl_pkg::OP_CHECK: begin
                    entry_valid_reg[s1_client_reg] <= 1'b1;
                end
                pcwrl_pkg::OP_RECORD: begin
                    entry_valid_reg[s1_client_reg] <= 1'b1;
                end
                pcwrl_pkg::OP_CLEAR: begin
                    entry_valid_reg[s1_client_reg] <= 1'b0;
                end
                default: begin
                    entry_valid_reg[s1_client_reg] <= entry_valid_reg[s1_client_reg];
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && has_result) begin
            m_data_reg <= result_data;
        end
    end

    // checks
    assign chk_fire  = s1_fire && (s1_op_reg == pcwrl_pkg::OP_CHECK);
    assign m_allowed = m_data_reg[0];
    assign m_retry   = m_data_reg[1+RW+NW +: pcwrl_pkg::RETRY_W];

    `PCWRL_ASSERT_NOW(a_stall_busy, aclk, aresetn, !s_tready, s1_valid_reg && m_valid_reg)
    `PCWRL_ASSERT_NOW(a_write_only_on_advance, aclk, aresetn, ram_wr_en, s1_fire)
    `PCWRL_ASSERT_NOW(a_retry_iff_denied, aclk, aresetn, m_valid_reg, m_allowed == (m_retry == '0))
    `PCWRL_ASSERT_NEXT(a_chk_valid, aclk, aresetn, chk_fire, entry_valid_reg[$past(s1_client_reg)])

endmodule

`default_nettype wire
